// ----- hdl/gcc3_pkg.sv -----
// Shared types, register indexes and kernel coefficients for the gray crop 3x3 convolver.
package gcc3_pkg;

  localparam int PIX_W  = 8;
  localparam int CFG_W  = 11;
  localparam int IDX_W  = 2;
  localparam int KSEL_W = 3;
  localparam int FW_W   = 11;
  localparam int FH_W   = 10;
  localparam int COEF_W = 5;
  localparam int COL_W  = 14;
  localparam int ACC_W  = 16;
  localparam int LINE_W = 2 * PIX_W;

  localparam logic [IDX_W-1:0] REG_KERNEL_SELECT = 2'd0;
  localparam logic [IDX_W-1:0] REG_GRAY_INPUT    = 2'd1;
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH   = 2'd2;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd3;

  localparam logic [KSEL_W-1:0] KSEL_HORIZ = 3'd1;
  localparam logic [KSEL_W-1:0] KSEL_VERT  = 3'd2;
  localparam logic [KSEL_W-1:0] KSEL_DIAG  = 3'd3;
  localparam logic [KSEL_W-1:0] KSEL_ANTI  = 3'd4;

  localparam logic [KSEL_W-1:0] KSEL_RESET   = KSEL_HORIZ;
  localparam logic [FW_W-1:0]   WIDTH_RESET  = 11'd640;
  localparam logic [FH_W-1:0]   HEIGHT_RESET = 10'd450;

  // row 0 sharpen, rows 1..4 follow the kernel codes
  localparam logic signed [COEF_W-1:0] KERNEL_TAB [5][9] = '{
    '{-5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd9, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
    '{-5'sd3, 5'sd0, 5'sd3, -5'sd10, 5'sd0, 5'sd10, -5'sd3, 5'sd0, 5'sd3},
    '{-5'sd3, -5'sd10, -5'sd3, 5'sd0, 5'sd0, 5'sd0, 5'sd3, 5'sd10, 5'sd3},
    '{-5'sd10, -5'sd3, 5'sd0, -5'sd3, 5'sd0, 5'sd3, 5'sd0, 5'sd3, 5'sd10},
    '{5'sd0, -5'sd3, -5'sd10, 5'sd3, 5'sd0, -5'sd3, 5'sd10, 5'sd3, 5'sd0}
  };

  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } column_t;

  function automatic logic signed [COEF_W-1:0] kcoef(input logic [KSEL_W-1:0] sel,
                                                     input logic [1:0] r,
                                                     input logic [1:0] c);
    logic [2:0] ki;
    case (sel)
      KSEL_HORIZ: ki = 3'd1;
      KSEL_VERT:  ki = 3'd2;
      KSEL_DIAG:  ki = 3'd3;
      KSEL_ANTI:  ki = 3'd4;
      default:    ki = 3'd0;
    endcase
    return KERNEL_TAB[ki][int'(r) * 3 + int'(c)];
  endfunction

endpackage

// ----- hdl/gcc3_ram.sv -----
// Simple dual-port RAM with one write port and one registered read port.
module gcc3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/gcc3_cell.sv -----
// Window cell: holds one 3-pixel column, passes it on when shifting, weights it by its kernel column.
module gcc3_cell #(
  parameter int COL = 0
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   shift,
  input  logic [gcc3_pkg::KSEL_W-1:0]            kernel_sel,
  input  gcc3_pkg::column_t                      col_in,
  output gcc3_pkg::column_t                      col_out,
  output logic signed [gcc3_pkg::COL_W-1:0]      col_sum
);

  logic signed [gcc3_pkg::COEF_W-1:0] c_top;
  logic signed [gcc3_pkg::COEF_W-1:0] c_mid;
  logic signed [gcc3_pkg::COEF_W-1:0] c_bot;
  logic signed [gcc3_pkg::COL_W-1:0]  p_top;
  logic signed [gcc3_pkg::COL_W-1:0]  p_mid;
  logic signed [gcc3_pkg::COL_W-1:0]  p_bot;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_out <= '0;
    end else if (shift) begin
      col_out <= col_in;
    end
  end

  always_comb begin
    c_top   = gcc3_pkg::kcoef(kernel_sel, 2'd0, 2'(COL));
    c_mid   = gcc3_pkg::kcoef(kernel_sel, 2'd1, 2'(COL));
    c_bot   = gcc3_pkg::kcoef(kernel_sel, 2'd2, 2'(COL));
    p_top   = $signed({1'b0, col_out.top}) * c_top;
    p_mid   = $signed({1'b0, col_out.mid}) * c_mid;
    p_bot   = $signed({1'b0, col_out.bot}) * c_bot;
    col_sum = p_top + p_mid + p_bot;
  end

endmodule

// ----- hdl/gray_crop_convolve3x3_core.sv -----
// Top level: gray conversion, centred square crop, two-line store and 3x3 convolution.
//
// Takes one pixel word per clock and keeps that pace while results are taken; a result for
// the pixel at crop position (r, c) with r, c >= 2 goes through the first stage, the window,
// the column sums and the output register. The two crop lines sit side by side
// in one RAM of MAX_SIDE 16-bit entries, read once per crop pixel when it is accepted and
// written back when the word leaves the first stage; a same-address collision is forwarded.
// The 3x3 window is a chain of three column cells, one column sum per cell; the sums are
// registered, then added and clamped into the output register. The crop geometry is
// recomputed from the registers in the cycle after a configuration write, and no pixel is
// taken in that cycle. The line store has no reset and no clearing pass; the first two crop
// rows of a frame fill it before any result depends on it.
module gray_crop_convolve3x3_core #(
  parameter int MAX_SIDE = 512,
  parameter int MAX_LINE = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gcc3_pkg::IDX_W-1:0]    cfg_index,
  input  logic [gcc3_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [31:0]                   pixel_word,
  input  logic                          frame_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gcc3_pkg::PIX_W-1:0]    filtered_pixel,
  output logic                          last_of_frame
);

  localparam int FW_W     = gcc3_pkg::FW_W;
  localparam int FH_W     = gcc3_pkg::FH_W;
  localparam int PIX_W    = gcc3_pkg::PIX_W;
  localparam int COL_W    = gcc3_pkg::COL_W;
  localparam int ACC_W    = gcc3_pkg::ACC_W;
  localparam int LINE_W   = gcc3_pkg::LINE_W;
  localparam int LINE_CAP = (MAX_LINE > 2047) ? 2047 : MAX_LINE;
  localparam int SIDE_CAP = (MAX_SIDE > 1023) ? 1023 : MAX_SIDE;
  localparam int CCW      = $clog2(LINE_CAP);
  localparam int RCW      = $clog2(SIDE_CAP);
  localparam int AW       = $clog2(MAX_SIDE);
  localparam logic [FW_W-1:0] W_MAX = FW_W'(LINE_CAP);
  localparam logic [FH_W-1:0] H_MAX = FH_W'(SIDE_CAP);
  localparam logic [FW_W-1:0] W_MIN = FW_W'(3);
  localparam logic [FH_W-1:0] H_MIN = FH_W'(3);

  // configuration
  logic [gcc3_pkg::KSEL_W-1:0] kernel_select;
  logic                        gray_input;
  logic [FW_W-1:0]             frame_width;
  logic [FH_W-1:0]             frame_height;
  logic                        geo_ok;

  // crop geometry
  logic [FW_W-1:0] w_c, w_eff, x0_c, x0, x_end;
  logic [FH_W-1:0] h_c, h_eff, side_c, side, y0_c, y0, y_end, side_m1;

  // position
  logic [CCW-1:0]  column_count;
  logic [RCW-1:0]  row_count;
  logic [CCW-1:0]  col0;
  logic [RCW-1:0]  row0;
  logic [FW_W-1:0] col_x, col_inc, cc_x;
  logic [FH_W-1:0] row_x, row_inc, cr_x;
  logic            in_crop, emit, last_px, acc;

  // gray conversion
  logic [12:0]      luma;
  logic [PIX_W-1:0] gray;

  // pipeline control
  logic v1, v2, v3;
  logic free1, free2, free3, ready3;
  logic mv1, ld2, ld3, ld_o, win_shift;

  // stage 1
  logic [PIX_W-1:0]  s1_gray;
  logic [AW-1:0]     s1_addr;
  logic              s1_crop, s1_emit, s1_last, s1_byp;
  logic [LINE_W-1:0] s1_byp_data;
  logic [LINE_W-1:0] line_q;

  // line store
  logic              ram_we, ram_re, byp_hit;
  logic [AW-1:0]     ram_raddr;
  logic [LINE_W-1:0] ram_wdata, ram_rdata;

  // window and sums
  gcc3_pkg::column_t                col_link [4];
  logic signed [COL_W-1:0]          col_sum [3];
  logic                             s2_last;
  logic signed [COL_W-1:0]          cs0, cs1, cs2;
  logic                             s3_last;
  logic signed [ACC_W-1:0]          acc_sum;
  logic [PIX_W-1:0]                 clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_select <= gcc3_pkg::KSEL_RESET;
      gray_input    <= 1'b0;
      frame_width   <= gcc3_pkg::WIDTH_RESET;
      frame_height  <= gcc3_pkg::HEIGHT_RESET;
      geo_ok        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gcc3_pkg::REG_KERNEL_SELECT: kernel_select <= cfg_data[gcc3_pkg::KSEL_W-1:0];
          gcc3_pkg::REG_GRAY_INPUT:    gray_input    <= cfg_data[0];
          gcc3_pkg::REG_FRAME_WIDTH:   frame_width   <= cfg_data[FW_W-1:0];
          gcc3_pkg::REG_FRAME_HEIGHT:  frame_height  <= cfg_data[FH_W-1:0];
          default: ;
        endcase
      end
      geo_ok <= !cfg_we;
    end
  end

  always_comb begin
    if (frame_width < W_MIN) begin
      w_c = W_MIN;
    end else if (frame_width > W_MAX) begin
      w_c = W_MAX;
    end else begin
      w_c = frame_width;
    end
    if (frame_height < H_MIN) begin
      h_c = H_MIN;
    end else if (frame_height > H_MAX) begin
      h_c = H_MAX;
    end else begin
      h_c = frame_height;
    end
    side_c = (w_c < FW_W'(h_c)) ? w_c[FH_W-1:0] : h_c;
    x0_c   = (w_c - FW_W'(side_c)) >> 1;
    y0_c   = (h_c - side_c) >> 1;
  end

  always_ff @(posedge clk) begin
    w_eff   <= w_c;
    h_eff   <= h_c;
    side    <= side_c;
    side_m1 <= side_c - FH_W'(1);
    x0      <= x0_c;
    y0      <= y0_c;
    x_end   <= x0_c + FW_W'(side_c);
    y_end   <= y0_c + side_c;
  end

  always_comb begin
    col0    = frame_start ? '0 : column_count;
    row0    = frame_start ? '0 : row_count;
    col_x   = (FW_W'(col0) >= w_eff) ? '0 : FW_W'(col0);
    row_x   = (FH_W'(row0) >= h_eff) ? '0 : FH_W'(row0);
    col_inc = col_x + FW_W'(1);
    row_inc = row_x + FH_W'(1);
    in_crop = (col_x >= x0) && (col_x < x_end) && (row_x >= y0) && (row_x < y_end);
    cc_x    = col_x - x0;
    cr_x    = row_x - y0;
    emit    = (cr_x >= FH_W'(2)) && (cc_x >= FW_W'(2));
    last_px = (cr_x == side_m1) && (cc_x == FW_W'(side_m1));
    luma    = 13'(pixel_word[23:16]) * 13'd11 + (13'(pixel_word[15:8]) << 4)
            + 13'(pixel_word[7:0]) * 13'd5;
    gray    = gray_input ? pixel_word[7:0] : luma[12:5];
  end

  // handshake chain: each stage moves when the next is empty or moving
  always_comb begin
    ready3    = !out_valid || out_ready;
    free3     = !v3 || ready3;
    free2     = !v2 || free3;
    free1     = !v1 || free2;
    in_ready  = free1 && geo_ok;
    acc       = in_valid && in_ready;
    mv1       = v1 && free2;
    win_shift = mv1 && s1_crop;
    ld2       = mv1 && s1_emit;
    ld3       = v2 && free3;
    ld_o      = v3 && ready3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (acc) begin
        if (col_inc >= w_eff) begin
          column_count <= '0;
          row_count    <= (row_inc >= h_eff) ? '0 : RCW'(row_inc);
        end else begin
          column_count <= CCW'(col_inc);
          row_count    <= RCW'(row_x);
        end
      end
      v1        <= acc ? 1'b1 : (free2 ? 1'b0 : v1);
      v2        <= ld2 ? 1'b1 : (free3 ? 1'b0 : v2);
      v3        <= ld3 ? 1'b1 : (ready3 ? 1'b0 : v3);
      out_valid <= ld_o ? 1'b1 : (out_ready ? 1'b0 : out_valid);
    end
  end

  // line store: read on accept, write back as the word leaves stage 1
  assign ram_re    = acc && in_crop;
  assign ram_raddr = AW'(cc_x);
  assign ram_we    = win_shift;
  assign line_q    = s1_byp ? s1_byp_data : ram_rdata;
  assign ram_wdata = {line_q[PIX_W-1:0], s1_gray};
  assign byp_hit   = ram_re && ram_we && (ram_raddr == s1_addr);

  gcc3_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_SIDE)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (s1_addr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_gray     <= gray;
      s1_addr     <= AW'(cc_x);
      s1_crop     <= in_crop;
      s1_emit     <= in_crop && emit;
      s1_last     <= last_px;
      s1_byp      <= byp_hit;
      s1_byp_data <= ram_wdata;
    end
  end

  assign col_link[3] = '{top: line_q[LINE_W-1:PIX_W], mid: line_q[PIX_W-1:0], bot: s1_gray};

  for (genvar i = 0; i < 3; i++) begin : g_cell
    gcc3_cell #(
      .COL (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (win_shift),
      .kernel_sel (kernel_select),
      .col_in     (col_link[i+1]),
      .col_out    (col_link[i]),
      .col_sum    (col_sum[i])
    );
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_last <= s1_last;
    end
    if (ld3) begin
      cs0     <= col_sum[0];
      cs1     <= col_sum[1];
      cs2     <= col_sum[2];
      s3_last <= s2_last;
    end
    if (ld_o) begin
      filtered_pixel <= clamped;
      last_of_frame  <= s3_last;
    end
  end

  always_comb begin
    acc_sum = ACC_W'(cs0) + ACC_W'(cs1) + ACC_W'(cs2);
    if (acc_sum < $signed(ACC_W'(0))) begin
      clamped = '0;
    end else if (acc_sum > $signed(ACC_W'(255))) begin
      clamped = 8'hFF;
    end else begin
      clamped = acc_sum[PIX_W-1:0];
    end
  end

  a_cfg_blocks_accept: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !in_ready)
    else $error("pixel accepted while crop geometry was stale");

  a_crop_in_line: assert property (@(posedge clk) disable iff (rst)
    acc && in_crop |-> cc_x < FW_W'(side))
    else $error("crop column beyond line store side");

  a_emit_in_crop: assert property (@(posedge clk) disable iff (rst)
    v1 && s1_emit |-> s1_crop)
    else $error("result scheduled for a pixel outside the crop");

  a_window_held: assert property (@(posedge clk) disable iff (rst)
    v2 && !free3 |-> !win_shift)
    else $error("window shifted under a stalled result");

  a_bypass_write: assert property (@(posedge clk) disable iff (rst)
    acc |=> !(s1_byp && s1_crop) || $past(ram_we))
    else $error("line store forward without a matching write");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for gray_crop_convolve3x3_core: random and directed pixel streams.
module tb_top;

  localparam int MAX_SIDE     = 512;
  localparam int MAX_LINE     = 1024;
  localparam int SETTLE_CYC   = 12;
  localparam int HOLD_CYC     = 300;
  localparam int WATCHDOG_CYC = 4000;
  localparam int N_RANDOM     = 900;

  localparam logic [gcc3_pkg::KSEL_W-1:0] KSEL_SHARPEN  = 3'd0;
  localparam logic [gcc3_pkg::KSEL_W-1:0] KSEL_SPARE_LO = 3'd5;

  // sharpen first, then horizontal, vertical, diagonal, antidiagonal Scharr
  localparam int TAPS [5][9] = '{
    '{ -1,  -1,  -1,  -1,   9,  -1,  -1,  -1,  -1},
    '{ -3,   0,   3, -10,   0,  10,  -3,   0,   3},
    '{ -3, -10,  -3,   0,   0,   0,   3,  10,   3},
    '{-10,  -3,   0,  -3,   0,   3,   0,   3,  10},
    '{  0,  -3, -10,   3,   0,  -3,  10,   3,   0}
  };

  typedef struct {
    logic [31:0] pix;
    logic        sof;
  } pixel_t;

  typedef struct {
    logic [gcc3_pkg::PIX_W-1:0] value;
    logic                       last;
  } result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [gcc3_pkg::IDX_W-1:0] cfg_index = gcc3_pkg::REG_KERNEL_SELECT;
  logic [gcc3_pkg::CFG_W-1:0] cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [31:0]                pixel_word = '0;
  logic                       frame_start = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [gcc3_pkg::PIX_W-1:0] filtered_pixel;
  logic                       last_of_frame;

  pixel_t  pix_q[$];
  result_t filtered_q[$];

  // predictor state
  logic [gcc3_pkg::KSEL_W-1:0] ksel_m = gcc3_pkg::KSEL_RESET;
  logic                        gray_m = 1'b0;
  logic [gcc3_pkg::FW_W-1:0]   width_m = gcc3_pkg::WIDTH_RESET;
  logic [gcc3_pkg::FH_W-1:0]   height_m = gcc3_pkg::HEIGHT_RESET;
  bit [7:0]                    line_m [2][MAX_SIDE];
  bit [7:0]                    win_m [3][3];
  int unsigned                 col_m = 0;
  int unsigned                 row_m = 0;

  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned quiet = 0;
  int          n_in = 0;
  int          n_out = 0;
  int          n_modes = 0;
  int          mismatches = 0;
  bit          burst = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  gray_crop_convolve3x3_core #(
    .MAX_SIDE(MAX_SIDE),
    .MAX_LINE(MAX_LINE)
  ) uut (
    .clk,
    .rst,
    .cfg_we,
    .cfg_index,
    .cfg_data,
    .in_valid,
    .in_ready,
    .pixel_word,
    .frame_start,
    .out_valid,
    .out_ready,
    .filtered_pixel,
    .last_of_frame
  );

  always #5 clk = ~clk;

  function automatic int unsigned pick_wait();
    if (burst || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // one accepted pixel: crop, line store, window shift and filtered word if interior
  function automatic void convolve_step(input logic [31:0] pix, input logic sof);
    int unsigned w, h, side, x0, y0, col, row, cc, cr, fam;
    int          acc, k, l;
    logic [7:0]  g, top, mid;
    result_t     r;
    w = (width_m < 3) ? 3 : (width_m > MAX_LINE) ? MAX_LINE : width_m;
    h = (height_m < 3) ? 3 : (height_m > MAX_SIDE) ? MAX_SIDE : height_m;
    side = (w < h) ? w : h;
    x0 = (w - side) / 2;
    y0 = (h - side) / 2;
    if (sof) begin
      col_m = 0;
      row_m = 0;
    end
    if (col_m >= w) col_m = 0;
    if (row_m >= h) row_m = 0;
    col = col_m;
    row = row_m;
    if (gray_m) g = pix[7:0];
    else g = 8'((11 * int'(pix[23:16]) + 16 * int'(pix[15:8]) + 5 * int'(pix[7:0])) >> 5);
    if (col >= x0 && col < x0 + side && row >= y0 && row < y0 + side) begin
      cc = col - x0;
      cr = row - y0;
      top = line_m[1][cc];
      mid = line_m[0][cc];
      line_m[1][cc] = mid;
      line_m[0][cc] = g;
      for (k = 0; k < 3; k++) begin
        win_m[k][0] = win_m[k][1];
        win_m[k][1] = win_m[k][2];
      end
      win_m[0][2] = top;
      win_m[1][2] = mid;
      win_m[2][2] = g;
      if (cr >= 2 && cc >= 2) begin
        case (ksel_m)
          gcc3_pkg::KSEL_HORIZ: fam = 1;
          gcc3_pkg::KSEL_VERT:  fam = 2;
          gcc3_pkg::KSEL_DIAG:  fam = 3;
          gcc3_pkg::KSEL_ANTI:  fam = 4;
          default:              fam = 0;
        endcase
        acc = 0;
        for (k = 0; k < 3; k++)
          for (l = 0; l < 3; l++)
            acc += TAPS[fam][k * 3 + l] * int'(win_m[k][l]);
        r.value = (acc > 255) ? 8'd255 : (acc < 0) ? 8'd0 : 8'(acc);
        r.last = (cr == side - 1 && cc == side - 1);
        filtered_q.push_back(r);
      end
    end
    if (col + 1 >= w) begin
      col_m = 0;
      row_m = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_m = col + 1;
    end
  endfunction

  task automatic write_reg(input logic [gcc3_pkg::IDX_W-1:0] idx,
                           input logic [gcc3_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      gcc3_pkg::REG_KERNEL_SELECT: ksel_m = data[gcc3_pkg::KSEL_W-1:0];
      gcc3_pkg::REG_GRAY_INPUT:    gray_m = data[0];
      gcc3_pkg::REG_FRAME_WIDTH:   width_m = data[gcc3_pkg::FW_W-1:0];
      gcc3_pkg::REG_FRAME_HEIGHT:  height_m = data[gcc3_pkg::FH_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // unused upper data bits carry noise on the narrow registers
  task automatic set_mode(input logic [gcc3_pkg::KSEL_W-1:0] k, input logic g,
                          input logic [gcc3_pkg::FW_W-1:0] w,
                          input logic [gcc3_pkg::FH_W-1:0] h,
                          input bit geom);
    write_reg(gcc3_pkg::REG_KERNEL_SELECT, {8'($urandom), k});
    write_reg(gcc3_pkg::REG_GRAY_INPUT, {10'($urandom), g});
    if (geom) begin
      write_reg(gcc3_pkg::REG_FRAME_WIDTH, w);
      write_reg(gcc3_pkg::REG_FRAME_HEIGHT, {1'b0, h});
    end
    n_modes++;
  endtask

  task automatic push_pixels(input int unsigned n, input bit sof, input bit noisy);
    int unsigned i;
    pixel_t      p;
    @(negedge clk);
    for (i = 0; i < n; i++) begin
      p.pix = rand_pixel();
      p.sof = (i == 0) ? sof : (noisy && $urandom_range(0, 63) == 0);
      pix_q.push_back(p);
    end
  endtask

  // sender holds back until every expected word is in and the pipe has drained
  task automatic settle();
    @(negedge clk);
    while (pix_q.size() != 0 || in_valid || filtered_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  always @(posedge clk) begin : feed
    bit          fire;
    int unsigned g;
    pixel_t      nxt;
    fire = in_valid && in_ready;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (fire) begin
        convolve_step(pixel_word, frame_start);
        n_in++;
      end
      if (!in_valid || fire) begin
        g = fire ? pick_wait() : gap_left;
        if (g != 0) begin
          in_valid <= 1'b0;
          gap_left <= g - 1;
        end else if (pix_q.size() != 0) begin
          nxt = pix_q.pop_front();
          pixel_word <= nxt.pix;
          frame_start <= nxt.sof;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : drain
    int unsigned s;
    result_t     e;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      s = (stall_left != 0) ? stall_left - 1 : 0;
      if (out_valid && out_ready) begin
        n_out++;
        if (filtered_q.size() == 0) begin
          $error("unexpected word: filtered_pixel %0d last_of_frame %0d",
                 filtered_pixel, last_of_frame);
          mismatches++;
        end else begin
          e = filtered_q.pop_front();
          if (filtered_pixel !== e.value) begin
            $error("filtered_pixel: expected %0d, got %0d", e.value, filtered_pixel);
            mismatches++;
          end
          if (last_of_frame !== e.last) begin
            $error("last_of_frame: expected %0d, got %0d", e.last, last_of_frame);
            mismatches++;
          end
        end
        s = pick_wait();
      end
      if (hold_req && !hold_done) begin
        s = HOLD_CYC;
        hold_done <= 1'b1;
      end
      stall_left <= s;
      out_ready <= (s == 0);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_CYC) begin
      $display("timeout: no word moved for %0d cycles", WATCHDOG_CYC);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int unsigned                 i, p, f, n, nfr, wf, hf, rand_items;
    logic [gcc3_pkg::KSEL_W-1:0] k;
    logic [gcc3_pkg::FW_W-1:0]   w;
    logic [gcc3_pkg::FH_W-1:0]   h;
    bit                          fresh;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // gray bytes, sharpen saturating high then low; no frame_start, second frame by wrap
    set_mode(KSEL_SHARPEN, 1'b1, 11'd3, 10'd3, 1'b1);
    @(negedge clk);
    for (i = 0; i < 18; i++)
      pix_q.push_back(pixel_t'{((i == 4) || (i >= 9 && i != 13)) ?
                               32'h0000_00FF : 32'hFFFF_FF00, 1'b0});
    settle();

    // zero geometry clamps to 3x3, spare kernel code, RGB extremes
    set_mode(KSEL_SPARE_LO, 1'b0, 11'd0, 10'd0, 1'b1);
    @(negedge clk);
    for (i = 0; i < 9; i++)
      pix_q.push_back(pixel_t'{(i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000, i == 0});
    settle();

    // back-pressure: output held off while words stream in back to back
    set_mode(gcc3_pkg::KSEL_HORIZ, 1'b0, 11'd12, 10'd10, 1'b1);
    @(negedge clk);
    burst = 1'b1;
    hold_req = 1'b1;
    push_pixels(120, 1'b1, 1'b0);
    settle();
    burst = 1'b0;

    rand_items = 0;
    p = 0;
    w = 11'd3;
    h = 10'd3;
    wf = 3;
    hf = 3;
    while (rand_items < N_RANDOM) begin
      k = (p < 8) ? p[2:0] : 3'($urandom_range(0, 7));
      fresh = (p == 0) || ($urandom_range(0, 3) != 0);
      if (fresh) begin
        w = ($urandom_range(0, 5) == 0) ? 11'($urandom_range(13, 24))
                                        : 11'($urandom_range(0, 12));
        h = 10'($urandom_range(0, 12));
        wf = (w < 3) ? 3 : w;
        hf = (h < 3) ? 3 : h;
      end
      // without new geometry the stream carries on mid-frame
      set_mode(k, 1'($urandom), w, h, fresh);
      nfr = $urandom_range(1, 2);
      for (f = 0; f < nfr; f++) begin
        n = wf * hf;
        case ($urandom_range(0, 7))
          0: n = $urandom_range(1, n - 1);
          1: n = n + $urandom_range(1, wf);
          default: ;
        endcase
        push_pixels(n, (f == 0) ? fresh : ($urandom_range(0, 4) != 0), 1'b1);
        rand_items += n;
      end
      settle();
      p++;
    end

    settle();
    $display("%0d pixel words over %0d register settings, %0d filtered words checked",
             n_in, n_modes, n_out);
    $display("kernel codes in turn, gray and RGB input, small and clamped crops, %0d errors",
             mismatches);
    if (mismatches == 0 && filtered_q.size() == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
